// ===== rtl/lgs_pkg.sv =====
// Package for the linear gradient shader: payload structs, register indexes
// and shared fixed-point constants. No dependencies.
package lgs_pkg;

    localparam int MAX_STOPS_DEF = 16;
    localparam int COORD_FRAC_DEF = 16;
    localparam int COLOR_FRAC_DEF = 15;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_MODE = 3'd0,
        REG_STOP_COUNT = 3'd1,
        REG_INV_SCALE_X = 3'd2,
        REG_INV_SKEW_Y = 3'd3,
        REG_INV_OFFSET = 3'd4
    } cfg_reg_t;

    localparam logic [1:0] TILE_CLAMP = 2'd0;
    localparam logic [1:0] TILE_REPEAT = 2'd1;
    localparam logic [1:0] TILE_MIRROR = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SHADE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               last_in_row;
        logic [3:0]         stop_index;
        logic [15:0]        stop_red;
        logic [15:0]        stop_green;
        logic [15:0]        stop_blue;
        logic [15:0]        stop_alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_done;
    } out_item_t;

endpackage

// ===== rtl/lgs_stop_mem.sv =====
// Stop color memory for the gradient shader: one write port and two
// registered read ports (lower and upper stop of a segment).
// Depends on lgs_pkg.
module lgs_stop_mem
    import lgs_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF,
    parameter int COLOR_FRAC_BITS = COLOR_FRAC_DEF,
    localparam int AW = $clog2(MAX_STOPS),
    localparam int CW = COLOR_FRAC_BITS + 1
)(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [4*CW-1:0] wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr_a,
    input  logic [AW-1:0]   rd_addr_b,
    output logic [4*CW-1:0] rd_data_a,
    output logic [4*CW-1:0] rd_data_b
);

    logic [4*CW-1:0] mem [MAX_STOPS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/linear_gradient_shader_unit.sv =====
// Linear gradient shader, top level: register file, coordinate pipeline,
// stop memory access, interpolation and output stage. Depends on lgs_pkg
// and lgs_stop_mem.
//
// The shader accepts one transaction per cycle, loads and shades alike, while
// the pipeline advances. A shade result passes through a pipeline eight
// registers deep before it reaches the output. A load gives no result. The
// rate is set by the stop memory: its write port takes one load per cycle
// and its pair of read ports serves one shade item per cycle. The multiplier
// stages are the coordinate products, segment position, blend, premultiply
// and scale. A load passes through the load delay line and writes the memory
// at the same pipeline position where a shade item reads it. Loads and shades
// therefore reach the memory in the order they were accepted. A shade sees
// every earlier load and no later one. The pipeline advances whenever the
// output register is empty or taken, so stall on the output only holds the
// block while results back up.
module linear_gradient_shader_unit
    import lgs_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int COLOR_FRAC_BITS = COLOR_FRAC_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = COLOR_FRAC_BITS + 1;
    localparam int FB = COORD_FRAC_BITS;
    localparam int CNTW = $clog2(MAX_STOPS + 1);
    localparam int STAGES = 8;
    localparam int WD = 3;
    localparam logic [CW-1:0] K_ONE = CW'(1) << COLOR_FRAC_BITS;
    localparam logic [FB:0] C_ONE = (FB+1)'(1) << FB;

    // Register file.
    logic [1:0]         tile_mode_reg;
    logic [4:0]         stop_count_reg;
    logic signed [31:0] inv_scale_x_reg;
    logic signed [31:0] inv_skew_y_reg;
    logic signed [31:0] inv_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_mode_reg <= TILE_CLAMP;
            stop_count_reg <= 5'd2;
            inv_scale_x_reg <= 32'sd1 <<< FB;
            inv_skew_y_reg <= '0;
            inv_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TILE_MODE:   tile_mode_reg <= cfg_data[1:0];
                REG_STOP_COUNT:  stop_count_reg <= cfg_data[4:0];
                REG_INV_SCALE_X: inv_scale_x_reg <= cfg_data;
                REG_INV_SKEW_Y:  inv_skew_y_reg <= cfg_data;
                REG_INV_OFFSET:  inv_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective stop count, clamped into one..MAX_STOPS.
    logic [CNTW-1:0] cnt_eff;
    always_comb
    begin
        if (stop_count_reg == 5'd0)
            cnt_eff = CNTW'(1);
        else if (32'(stop_count_reg) > MAX_STOPS)
            cnt_eff = CNTW'(MAX_STOPS);
        else
            cnt_eff = CNTW'(stop_count_reg);
    end

    // Pipeline control: all stages advance together.
    logic             adv;
    logic [STAGES-1:0] vld_reg;
    assign adv = !out_valid || !out_stall;
    assign in_stall = !adv;

    logic acc_in;
    assign acc_in = in_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], acc_in && in_item.mode == MODE_SHADE};
    end

    // Stop loads: saturate channels above one.
    function automatic logic [CW-1:0] sat_ch(input logic [15:0] v);
        logic [16:0] k;
        k = 17'(K_ONE);
        sat_ch = ({1'b0, v} > k) ? K_ONE : CW'(v);
    endfunction

    logic            mem_wr;
    logic [4*CW-1:0] mem_wdata;
    assign mem_wr = acc_in && in_item.mode == MODE_LOAD
                    && 32'(in_item.stop_index) < MAX_STOPS;
    assign mem_wdata = {sat_ch(in_item.stop_red), sat_ch(in_item.stop_green),
                        sat_ch(in_item.stop_blue), sat_ch(in_item.stop_alpha)};

    // Load delay line: a load travels to the read stage before it writes,
    // so the memory sees loads and shades in acceptance order.
    logic [WD-1:0]   ld_vld_reg;
    logic [AW-1:0]   ld_addr_reg [WD];
    logic [4*CW-1:0] ld_data_reg [WD];
    logic            mem_wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_vld_reg <= '0;
        else if (adv)
            ld_vld_reg <= {ld_vld_reg[WD-2:0], mem_wr};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_addr_reg[0] <= AW'(in_item.stop_index);
            ld_data_reg[0] <= mem_wdata;
            for (int i = 1; i < WD; i++)
            begin
                ld_addr_reg[i] <= ld_addr_reg[i-1];
                ld_data_reg[i] <= ld_data_reg[i-1];
            end
        end
    end

    assign mem_wr_en = ld_vld_reg[WD-1] && adv;

    // Stage 1: coordinate products, x2 to carry the pixel-center half.
    logic signed [49:0] px_prod_reg, py_prod_reg;
    logic               row1_reg;
    logic signed [16:0] px2, py2;
    assign px2 = {in_item.pixel_x, 1'b1};
    assign py2 = {in_item.pixel_y, 1'b1};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_prod_reg <= 50'(inv_scale_x_reg * px2);
            py_prod_reg <= 50'(inv_skew_y_reg * py2);
            row1_reg <= in_item.last_in_row;
        end
    end

    // Stage 2: sum, floor halve, tile.
    logic signed [51:0] acc_sum;
    logic signed [50:0] tq;
    logic [FB:0]        u_val;
    logic [FB-1:0]      tfrac;
    logic               ip_odd;
    logic [FB:0]        u_reg;
    logic               row2_reg;

    assign acc_sum = 52'(px_prod_reg) + 52'(py_prod_reg) + (52'(inv_offset_reg) <<< 1);
    assign tq = acc_sum[51:1];
    assign tfrac = tq[FB-1:0];
    assign ip_odd = tq[FB];

    always_comb
    begin
        case (tile_mode_reg)
            TILE_CLAMP:
            begin
                if (tq < 0)
                    u_val = '0;
                else if (tq >= 51'(C_ONE))
                    u_val = C_ONE - (FB+1)'(1);
                else
                    u_val = (FB+1)'(tq);
            end
            TILE_REPEAT: u_val = {1'b0, tfrac};
            TILE_MIRROR: u_val = ip_odd ? C_ONE - {1'b0, tfrac} : {1'b0, tfrac};
            default:     u_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg <= u_val;
            row2_reg <= row1_reg;
        end
    end

    // Stage 3: segment position u * (count - 1).
    logic [FB+CNTW:0] pos_reg;
    logic             row3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg <= (FB+CNTW+1)'(u_reg) * (FB+CNTW+1)'(cnt_eff - CNTW'(1));
            row3_reg <= row2_reg;
        end
    end

    // Segment index and weight; issue stop reads.
    logic [CNTW:0]  k_raw;
    logic [AW-1:0]  k_sel, k_hi;
    logic [FB:0]    f_sel;
    logic           flat;
    assign k_raw = pos_reg[FB+CNTW:FB];
    assign flat = cnt_eff == CNTW'(1);

    always_comb
    begin
        if (flat)
        begin
            k_sel = '0;
            k_hi = '0;
            f_sel = '0;
        end
        else if (k_raw >= (CNTW+1)'(cnt_eff - CNTW'(1)))
        begin
            k_sel = AW'(cnt_eff - CNTW'(2));
            k_hi = AW'(cnt_eff - CNTW'(1));
            f_sel = C_ONE;
        end
        else
        begin
            k_sel = AW'(k_raw);
            k_hi = AW'(k_raw + (CNTW+1)'(1));
            f_sel = {1'b0, pos_reg[FB-1:0]};
        end
    end

    logic [4*CW-1:0] rd_a, rd_b;
    lgs_stop_mem #(
        .MAX_STOPS(MAX_STOPS),
        .COLOR_FRAC_BITS(COLOR_FRAC_BITS)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (ld_addr_reg[WD-1]),
        .wr_data   (ld_data_reg[WD-1]),
        .rd_en     (adv),
        .rd_addr_a (k_sel),
        .rd_addr_b (k_hi),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // Stage 4: memory read in flight; carry weight along.
    logic [FB:0] f4_reg;
    logic        row4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f4_reg <= f_sel;
            row4_reg <= row3_reg;
        end
    end

    // Stage 5: blend products per channel.
    localparam int BW = CW + FB + 2;
    logic [BW-1:0] blend_reg [4];
    logic          row5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                blend_reg[j] <= BW'(rd_a[j*CW +: CW]) * BW'(C_ONE - f4_reg)
                              + BW'(rd_b[j*CW +: CW]) * BW'(f4_reg);
            end
            row5_reg <= row4_reg;
        end
    end

    // Stage 6: round channels back to color precision.
    logic [CW-1:0] ch_reg [4];
    logic          row6_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ch_reg[j] <= CW'((blend_reg[j] + BW'(C_ONE >> 1)) >> FB);
            end
            row6_reg <= row5_reg;
        end
    end

    // Stage 7: premultiply by alpha.
    logic [2*CW-1:0] pm_reg [3];
    logic [CW-1:0]   a7_reg;
    logic            row7_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pm_reg[j] <= (2*CW)'(ch_reg[j+1]) * (2*CW)'(ch_reg[0]);
            end
            a7_reg <= ch_reg[0];
            row7_reg <= row6_reg;
        end
    end

    // Stage 8: scale to 8 bits with round half up, into the output register.
    localparam int PS = 2 * COLOR_FRAC_BITS;
    localparam int SW = 2 * CW + 8;
    function automatic logic [7:0] to8_pm(input logic [2*CW-1:0] v);
        logic [SW-1:0] s;
        s = SW'(v) * SW'(255) + (SW'(1) << (PS - 1));
        to8_pm = s[PS +: 8];
    endfunction
    function automatic logic [7:0] to8_a(input logic [CW-1:0] v);
        logic [CW+8:0] s;
        s = (CW+9)'(v) * (CW+9)'(255) + ((CW+9)'(1) << (COLOR_FRAC_BITS - 1));
        to8_a = s[COLOR_FRAC_BITS +: 8];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item.red <= to8_pm(pm_reg[2]);
            out_item.green <= to8_pm(pm_reg[1]);
            out_item.blue <= to8_pm(pm_reg[0]);
            out_item.alpha <= to8_a(a7_reg);
            out_item.row_done <= row7_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];

    // Assertions.
    a_no_take_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_item.mode == MODE_LOAD) |=> !vld_reg[0])
        else $error("load entered the shade pipeline");
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");
    a_shade_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_item.mode == MODE_SHADE) |=> vld_reg[0])
        else $error("shade transaction lost");

endmodule
